### rtl/source_text_tokenizer_macros.svh
// assertion macros shared by the tokenizer checker
`ifndef SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_MACROS_SVH

// same-cycle implication, held off while reset is low
`define STT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// next-cycle implication, held off while reset is low
`define STT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

### rtl/stt_pkg.sv
// types, codes and character helpers for the source text tokenizer
package stt_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int MAX_TOKENS = 3;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_IDENT   = 3'd1,
        MODE_INT     = 3'd2,
        MODE_FRAC    = 3'd3,
        MODE_COMMENT = 3'd4,
        MODE_EQ      = 3'd5,
        MODE_ERROR   = 3'd6
    } mode_t;

    typedef enum logic [3:0] {
        K_LPAREN = 4'd0,
        K_RPAREN = 4'd1,
        K_COMMA  = 4'd2,
        K_EOL    = 4'd3,
        K_PLUS   = 4'd4,
        K_MINUS  = 4'd5,
        K_STAR   = 4'd6,
        K_SLASH  = 4'd7,
        K_LESS   = 4'd8,
        K_EQUAL  = 4'd9,
        K_EQEQ   = 4'd10,
        K_NUMBER = 4'd11,
        K_IDENT  = 4'd12,
        K_DEF    = 4'd13,
        K_EXTERN = 4'd14,
        K_ERROR  = 4'd15
    } kind_t;

    // keyword match progress: "def" runs 1..3, "extern" runs 4..9
    localparam logic [3:0] KW_NONE      = 4'd0;
    localparam logic [3:0] KW_DEF_START = 4'd1;
    localparam logic [3:0] KW_DEF_DONE  = 4'd3;
    localparam logic [3:0] KW_EXT_START = 4'd4;
    localparam logic [3:0] KW_EXT_DONE  = 4'd9;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LOWER_D = 8'h64;
    localparam logic [7:0] CH_LOWER_E = 8'h65;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [15:0] line;
        logic [15:0] column;
    } token_t;

    typedef struct packed {
        token_t [MAX_TOKENS-1:0] tok;
        logic   [1:0]            count;
    } bundle_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || (c == CH_UNDER);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // next byte expected by the keyword matcher, zero where none
    function automatic logic [7:0] kw_next(input logic [3:0] kp);
        logic [7:0] r;
        unique case (kp)
            4'd1:    r = 8'h65; // e
            4'd2:    r = 8'h66; // f
            4'd4:    r = 8'h78; // x
            4'd5:    r = 8'h74; // t
            4'd6:    r = 8'h65; // e
            4'd7:    r = 8'h72; // r
            4'd8:    r = 8'h6E; // n
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic kind_t punct_kind(input logic [7:0] c);
        kind_t k;
        unique case (c)
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h2C:   k = K_COMMA;
            8'h3B:   k = K_EOL;
            8'h2B:   k = K_PLUS;
            8'h2D:   k = K_MINUS;
            8'h2A:   k = K_STAR;
            8'h2F:   k = K_SLASH;
            8'h3C:   k = K_LESS;
            default: k = K_ERROR;
        endcase
        return k;
    endfunction

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v != 16'hFFFF) ? 16'(v + 16'd1) : v;
    endfunction

endpackage

### rtl/stt_scanner.sv
// scanner state and the per-byte token decision
module stt_scanner import stt_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] text_byte,
    input  logic       final_byte,
    output bundle_t    bundle
);

    localparam int P = POSITION_BITS;

    mode_t          mode_reg, mode_next;
    logic [P-1:0]   pos_reg, pos_next;
    logic [P-1:0]   pstart_reg, pstart_next;
    logic [15:0]    line_reg, line_next;
    logic [15:0]    col_reg, col_next;
    logic [3:0]     kp_reg, kp_next;

    function automatic logic [15:0] sat16(input logic [P-1:0] v);
        return ((P > 16) && ((v >> 16) != '0)) ? 16'hFFFF : 16'(v);
    endfunction

    function automatic token_t make_tok(input kind_t k, input logic [P-1:0] st,
                                        input logic [P-1:0] len,
                                        input logic [15:0] ln, input logic [15:0] cl);
        token_t t;
        t.kind   = k;
        t.start  = sat16(st);
        t.length = sat16(len);
        t.line   = ln;
        t.column = cl;
        return t;
    endfunction

    function automatic kind_t held_kind(input mode_t md, input logic [3:0] kp);
        kind_t k;
        if (md == MODE_IDENT) begin
            k = (kp == KW_DEF_DONE) ? K_DEF : (kp == KW_EXT_DONE) ? K_EXTERN : K_IDENT;
        end else if (md == MODE_EQ) begin
            k = K_EQUAL;
        end else begin
            k = K_NUMBER;
        end
        return k;
    endfunction

    always_comb begin
        mode_t        md;
        logic [3:0]   kp;
        logic [P-1:0] ps;
        logic [P-1:0] pos;
        logic [P-1:0] aft;
        logic [15:0]  ln;
        logic [15:0]  cl;
        logic [1:0]   n;
        logic         consumed;
        kind_t        pk;
        bundle_t      b;

        md       = mode_reg;
        kp       = kp_reg;
        ps       = pstart_reg;
        pos      = pos_reg;
        aft      = (pos_reg != '1) ? P'(pos_reg + 1'b1) : pos_reg;
        ln       = line_reg;
        cl       = col_reg;
        n        = 2'd0;
        consumed = 1'b0;
        pk       = punct_kind(text_byte);
        b        = '0;

        // continue or close a held-open token
        unique case (md)
            MODE_ERROR: begin
                consumed = 1'b1;
            end
            MODE_IDENT: begin
                if (is_alpha(text_byte) || is_digit(text_byte)) begin
                    cl = sat_inc16(cl);
                    kp = (kw_next(kp) != 8'h00 && kw_next(kp) == text_byte)
                         ? 4'(kp + 4'd1) : KW_NONE;
                    consumed = 1'b1;
                end else begin
                    b.tok[n] = make_tok(held_kind(md, kp), ps, P'(pos - ps), ln, cl);
                    n  = 2'(n + 2'd1);
                    md = MODE_IDLE;
                end
            end
            MODE_INT, MODE_FRAC: begin
                if (is_digit(text_byte)) begin
                    cl = sat_inc16(cl);
                    consumed = 1'b1;
                end else if (text_byte == CH_DOT && md == MODE_INT) begin
                    cl = sat_inc16(cl);
                    md = MODE_FRAC;
                    consumed = 1'b1;
                end else begin
                    b.tok[n] = make_tok(K_NUMBER, ps, P'(pos - ps), ln, cl);
                    n  = 2'(n + 2'd1);
                    md = MODE_IDLE;
                end
            end
            MODE_COMMENT: begin
                if (text_byte != CH_NEWLINE) begin
                    cl = sat_inc16(cl);
                    consumed = 1'b1;
                end else begin
                    md = MODE_IDLE;
                end
            end
            MODE_EQ: begin
                if (text_byte == CH_EQUAL) begin
                    cl = sat_inc16(cl);
                    b.tok[n] = make_tok(K_EQEQ, ps, P'(aft - ps), ln, cl);
                    n  = 2'(n + 2'd1);
                    md = MODE_IDLE;
                    consumed = 1'b1;
                end else begin
                    b.tok[n] = make_tok(K_EQUAL, ps, P'(pos - ps), ln, cl);
                    n  = 2'(n + 2'd1);
                    md = MODE_IDLE;
                end
            end
            default: begin
                md = MODE_IDLE;
            end
        endcase

        // byte not taken by a held token starts afresh
        if (!consumed) begin
            ps = pos;
            cl = sat_inc16(cl);
            if (is_space(text_byte)) begin
                if (text_byte == CH_NEWLINE) begin
                    ln = sat_inc16(ln);
                    cl = 16'd1;
                end
            end else if (is_alpha(text_byte)) begin
                md = MODE_IDENT;
                kp = (text_byte == CH_LOWER_D) ? KW_DEF_START :
                     (text_byte == CH_LOWER_E) ? KW_EXT_START : KW_NONE;
            end else if (is_digit(text_byte)) begin
                md = MODE_INT;
            end else if (text_byte == CH_HASH) begin
                md = MODE_COMMENT;
            end else if (text_byte == CH_EQUAL) begin
                md = MODE_EQ;
            end else begin
                b.tok[n] = make_tok(pk, pos, P'(aft - pos), ln, cl);
                n = 2'(n + 2'd1);
                if (pk == K_ERROR) begin
                    md = MODE_ERROR;
                end
            end
        end

        // end of source: flush, closing eol, back to reset values
        if (final_byte) begin
            if (md == MODE_IDENT || md == MODE_INT || md == MODE_FRAC || md == MODE_EQ) begin
                b.tok[n] = make_tok(held_kind(md, kp), ps, P'(aft - ps), ln, cl);
                n = 2'(n + 2'd1);
            end
            b.tok[n] = make_tok(K_EOL, aft, '0, ln, cl);
            n   = 2'(n + 2'd1);
            md  = MODE_IDLE;
            kp  = KW_NONE;
            ps  = '0;
            aft = '0;
            ln  = 16'd1;
            cl  = 16'd1;
        end

        b.count     = n;
        bundle      = b;
        mode_next   = md;
        kp_next     = kp;
        pstart_next = ps;
        pos_next    = aft;
        line_next   = ln;
        col_next    = cl;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            kp_reg     <= KW_NONE;
            pstart_reg <= '0;
            pos_reg    <= '0;
            line_reg   <= 16'd1;
            col_reg    <= 16'd1;
        end else if (accept) begin
            mode_reg   <= mode_next;
            kp_reg     <= kp_next;
            pstart_reg <= pstart_next;
            pos_reg    <= pos_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
        end
    end

endmodule

### rtl/stt_result_queue.sv
// holds the tokens of one byte and hands them out one word at a time
module stt_result_queue import stt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  bundle_t     bundle,
    output logic        free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    output logic [3:0]  m_tuser,
    output logic        m_tlast
);

    bundle_t    bundle_reg;
    logic [1:0] idx_reg, idx_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       last_one;
    token_t     cur;

    assign m_tvalid = (idx_reg != cnt_reg);
    assign last_one = (2'(idx_reg + 2'd1) == cnt_reg);
    // a new byte may land while the final token of the previous one leaves
    assign free     = !m_tvalid || (m_tready && last_one);

    assign cur     = bundle_reg.tok[idx_reg];
    assign m_tdata = {cur.column, cur.line, cur.length, cur.start};
    assign m_tuser = cur.kind;
    assign m_tlast = last_one;

    always_comb begin
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        if (push) begin
            idx_next = 2'd0;
            cnt_next = bundle.count;
        end else if (m_tvalid && m_tready) begin
            idx_next = 2'(idx_reg + 2'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 2'd0;
            cnt_reg <= 2'd0;
        end else begin
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            bundle_reg <= bundle;
        end
    end

endmodule

### rtl/source_text_tokenizer.sv
// source text tokenizer: one source byte in per word, tokens out
// output: the first token of a byte is offered in the cycle after that byte is taken
// throughput: one byte per cycle while each byte yields at most one token and the output
//   is not stalled; a byte yielding more tokens holds the input until its last token leaves
// reset: synchronous active-low aresetn clears the scan state and drops pending tokens;
//   the last byte of a source also returns the scanner to its reset state
module source_text_tokenizer import stt_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [7:0] text_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,  // [15:0] token_start, [31:16] token_length,
                                  // [47:32] token_line, [63:48] token_column
    output logic [3:0]  m_tuser,  // [3:0] token_kind
    output logic        m_tlast
);

    logic    accept;
    bundle_t bundle;

    assign accept = s_tvalid && s_tready;

    stt_scanner #(
        .POSITION_BITS(POSITION_BITS)
    ) u_scanner (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .text_byte  (s_tdata),
        .final_byte (s_tlast),
        .bundle     (bundle)
    );

    stt_result_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (accept),
        .bundle   (bundle),
        .free     (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### rtl/stt_checker.sv
// port-level checks for the source text tokenizer, bound to the top level
`include "source_text_tokenizer_macros.svh"

module stt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);

    logic s_word;
    logic m_stall;

    assign s_word  = s_tvalid && s_tready && (s_tlast || (s_tdata != 8'h00));
    assign m_stall = m_tvalid && !m_tready;

    // an idle output never blocks the input
    `STT_ASSERT_SAME(a_idle_ready, aclk, aresetn, !m_tvalid, s_tready)
    // line and column counters start at one and never wrap to zero
    `STT_ASSERT_SAME(a_line_col_nonzero, aclk, aresetn, m_tvalid,
        (m_tdata[47:32] != 16'd0) && (m_tdata[63:48] != 16'd0))
    // input is held off while any token waits on a stalled output
    `STT_ASSERT_SAME(a_hold_input, aclk, aresetn, m_stall, !s_tready && !s_word)
    // a stalled token stays offered unchanged
    `STT_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_stall,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
